// ----- rtl/cell_list_counting_sort_assert.svh -----
// Assertion macros used by the cell list sort top level.
`ifndef CELL_LIST_COUNTING_SORT_ASSERT_SVH
`define CELL_LIST_COUNTING_SORT_ASSERT_SVH

// Checks a condition at every clock edge outside reset.
`define CLCS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("cell list sort: invariant violated");

// Checks that a condition implies another in the same cycle.
`define CLCS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cell list sort: implication violated");

// Checks that a condition implies another in the next cycle.
`define CLCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cell list sort: sequence violated");

`endif

// ----- rtl/clcs_pkg.sv -----
// Package with the types and constants of the cell list sort block.
`timescale 1ns / 1ps

package clcs_pkg;

    localparam logic [12:0] MAX_PARTICLES = 13'd4096;
    localparam logic [12:0] MAX_CELLS     = 13'd4096;
    localparam int          PIDX_W        = 12;
    localparam int          CIDX_W        = 12;
    localparam logic [12:0] LAST_CELL     = 13'd4095;
    localparam logic [6:0]  GRID_MAX      = 7'd64;

    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_BUILD = 3'd2;
    localparam logic [2:0] OP_RSLOT = 3'd3;
    localparam logic [2:0] OP_RCELL = 3'd4;

    localparam logic [1:0] CFG_CELLS_X  = 2'd0;
    localparam logic [1:0] CFG_CELLS_Y  = 2'd1;
    localparam logic [1:0] CFG_INV_SIZE = 2'd2;
    localparam logic [1:0] CFG_WRAP     = 2'd3;

    typedef struct packed {
        logic [23:0] inv;
        logic [6:0]  dim;
        logic        wrap;
    } axis_cfg_t;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX,
        A_DONE
    } axis_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AXIS,
        ST_LD_RD,
        ST_LD_WR,
        ST_PFX,
        ST_SC_RD0,
        ST_SC_RD1,
        ST_SC_WR,
        ST_RQ,
        ST_RS,
        ST_DONE
    } top_state_t;

endpackage

// ----- rtl/clcs_axis.sv -----
// Cell coordinate of one axis: fixed-point scale, floor, then wrap or clamp.
`timescale 1ns / 1ps

module clcs_axis (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [31:0]      pos,
    input  clcs_pkg::axis_cfg_t     cfg,
    output logic                    done,
    output logic [5:0]              coord
);

    clcs_pkg::axis_state_t state_reg, state_next;
    logic signed [55:0] prod_reg, prod_next;
    logic [23:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [6:0]         rem_reg, rem_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [5:0]         coord_reg, coord_next;
    logic signed [56:0] prod_full;
    logic signed [23:0] cval;

    assign prod_full = 57'(pos) * 57'($signed({1'b0, cfg.inv}));
    assign cval      = prod_reg[55:32];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            clcs_pkg::A_IDLE: if (start) state_next = clcs_pkg::A_MUL;
            clcs_pkg::A_MUL:  state_next = cfg.wrap ? clcs_pkg::A_DIV : clcs_pkg::A_DONE;
            clcs_pkg::A_DIV:  if (cnt_reg == 3'd5) state_next = clcs_pkg::A_FIX;
            clcs_pkg::A_FIX:  state_next = clcs_pkg::A_DONE;
            clcs_pkg::A_DONE: state_next = clcs_pkg::A_IDLE;
            default:          state_next = clcs_pkg::A_IDLE;
        endcase
    end

    always_comb begin
        logic [6:0]  r;
        logic [23:0] m;
        prod_next  = prod_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        coord_next = coord_reg;
        r = rem_reg;
        m = mag_reg;
        case (state_reg)
            clcs_pkg::A_IDLE: begin
                if (start) prod_next = prod_full[55:0];
            end
            clcs_pkg::A_MUL: begin
                neg_next = cval[23];
                mag_next = cval[23] ? 24'(-cval) : 24'(cval);
                rem_next = 7'd0;
                cnt_next = 3'd0;
                if (cval[23]) begin
                    coord_next = 6'd0;
                end else if (cval >= $signed({17'd0, cfg.dim})) begin
                    coord_next = 6'(cfg.dim - 7'd1);
                end else begin
                    coord_next = cval[5:0];
                end
            end
            clcs_pkg::A_DIV: begin
                for (int j = 0; j < 4; j++) begin
                    r = {r[5:0], m[23]};
                    m = {m[22:0], 1'b0};
                    if (r >= cfg.dim) r = r - cfg.dim;
                end
                rem_next = r;
                mag_next = m;
                cnt_next = cnt_reg + 3'd1;
            end
            clcs_pkg::A_FIX: begin
                coord_next = (neg_reg && rem_reg != 7'd0) ? 6'(cfg.dim - rem_reg)
                                                         : rem_reg[5:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clcs_pkg::A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        prod_reg  <= prod_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        coord_reg <= coord_next;
    end

    assign done  = (state_reg == clcs_pkg::A_DONE);
    assign coord = coord_reg;

endmodule

// ----- rtl/cell_list_counting_sort.sv -----
// Top level of the cell list counting sort block.
`timescale 1ns / 1ps
`include "cell_list_counting_sort_assert.svh"
// Usage: commands arrive on the s_ stream, opcode in s_tuser; every command
// gives exactly one result transfer on the m_ stream. The block works on one
// command at a time and takes the next one while a result still waits.
// Steps from input transfer to result register:
//   load with wrap_mode set: multiply, floor, six remainder steps of four
//   bits, count update; load with clamping: multiply, floor, count update;
//   load when full and unused opcode: straight to the result;
//   read slot and read cell: the registered memory reads;
//   clear: one pass over the 4096 cell entries;
//   build: a prefix pass over all cells and then, for the scatter, two
//   memory reads and a memory write per loaded particle.
// After reset the block runs the same clearing pass over the 4096 cell entries and keeps
// s_tready low until it ends; configuration writes are taken at any time.
// If the receiver stalls, the finished result holds in the output register;
// one further command may be taken and worked, and its result waits for the
// register to empty before the block becomes ready again.

module cell_list_counting_sort (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // pos_x, pos_y, slot, cell_req
    input  logic [2:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // cell_id, particle_index, cell_offset, cell_count,
                                   // particle_total, overflow
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int PW = clcs_pkg::PIDX_W;
    localparam int CW = clcs_pkg::CIDX_W;

    clcs_pkg::top_state_t state_reg, state_next;

    logic [6:0]  cells_x_reg, cells_y_reg;
    logic [23:0] inv_reg;
    logic        wrap_reg;

    logic [12:0] idx_reg, idx_next;
    logic [12:0] acc_reg, acc_next;
    logic [12:0] pidx_reg, pidx_next;
    logic [12:0] loaded_reg, loaded_next;
    logic        ovf_reg, ovf_next;
    logic        pend_reg, pend_next;
    logic [2:0]  op_reg, op_next;
    logic [11:0] slot_reg, slot_next;
    logic [11:0] creq_reg, creq_next;
    logic [11:0] id_reg, id_next;
    logic [11:0] res_cell_reg, res_cell_next;
    logic [11:0] res_part_reg, res_part_next;
    logic [12:0] res_off_reg, res_off_next;
    logic [12:0] res_cnt_reg, res_cnt_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;

    logic [12:0] cnt_mem [0:4095];
    logic [12:0] off_mem [0:4095];
    logic [12:0] cur_mem [0:4095];
    logic [11:0] pc_mem  [0:4095];
    logic [11:0] ss_mem  [0:4095];

    logic          cnt_we, off_we, cur_we, pc_we, ss_we;
    logic [CW-1:0] cnt_waddr, cnt_raddr, off_waddr, off_raddr, cur_waddr, cur_raddr;
    logic [PW-1:0] pc_waddr, pc_raddr, ss_waddr, ss_raddr;
    logic [12:0]   cnt_wdata, off_wdata, cur_wdata, cnt_rdata, off_rdata, cur_rdata;
    logic [11:0]   pc_wdata, ss_wdata, pc_rdata, ss_rdata;

    logic        accept, full, out_free;
    logic [6:0]  nx, ny;
    logic        x_done, y_done;
    logic [5:0]  cx, cy;
    logic [12:0] id_full;
    logic [13:0] slot_k;
    clcs_pkg::axis_cfg_t cfg_x, cfg_y;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == clcs_pkg::ST_IDLE);
    assign full     = (loaded_reg >= clcs_pkg::MAX_PARTICLES);
    assign out_free = !m_tvalid_reg || m_tready;

    assign nx = (cells_x_reg == 7'd0) ? 7'd1 :
                (cells_x_reg > clcs_pkg::GRID_MAX) ? clcs_pkg::GRID_MAX : cells_x_reg;
    assign ny = (cells_y_reg == 7'd0) ? 7'd1 :
                (cells_y_reg > clcs_pkg::GRID_MAX) ? clcs_pkg::GRID_MAX : cells_y_reg;

    assign cfg_x = '{inv: inv_reg, dim: nx, wrap: wrap_reg};
    assign cfg_y = '{inv: inv_reg, dim: ny, wrap: wrap_reg};

    clcs_axis u_axis_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_tuser == clcs_pkg::OP_LOAD && !full),
        .pos     ($signed(s_tdata[31:0])),
        .cfg     (cfg_x),
        .done    (x_done),
        .coord   (cx)
    );

    clcs_axis u_axis_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept && s_tuser == clcs_pkg::OP_LOAD && !full),
        .pos     ($signed(s_tdata[63:32])),
        .cfg     (cfg_y),
        .done    (y_done),
        .coord   (cy)
    );

    assign id_full = 13'(cy * nx) + 13'(cx);
    assign slot_k  = 14'(off_rdata) + 14'(cur_rdata);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            clcs_pkg::ST_CLEAR: begin
                if (idx_reg == clcs_pkg::LAST_CELL) begin
                    state_next = pend_reg ? clcs_pkg::ST_DONE : clcs_pkg::ST_IDLE;
                end
            end
            clcs_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        clcs_pkg::OP_CLEAR: state_next = clcs_pkg::ST_CLEAR;
                        clcs_pkg::OP_LOAD:
                            state_next = full ? clcs_pkg::ST_DONE : clcs_pkg::ST_AXIS;
                        clcs_pkg::OP_BUILD: state_next = clcs_pkg::ST_PFX;
                        clcs_pkg::OP_RSLOT: state_next = clcs_pkg::ST_RQ;
                        clcs_pkg::OP_RCELL: state_next = clcs_pkg::ST_RQ;
                        default:            state_next = clcs_pkg::ST_DONE;
                    endcase
                end
            end
            clcs_pkg::ST_AXIS:   if (x_done) state_next = clcs_pkg::ST_LD_RD;
            clcs_pkg::ST_LD_RD:  state_next = clcs_pkg::ST_LD_WR;
            clcs_pkg::ST_LD_WR:  state_next = clcs_pkg::ST_DONE;
            clcs_pkg::ST_PFX: begin
                if (idx_reg == clcs_pkg::MAX_CELLS) state_next = clcs_pkg::ST_SC_RD0;
            end
            clcs_pkg::ST_SC_RD0: begin
                state_next = (pidx_reg >= loaded_reg) ? clcs_pkg::ST_DONE
                                                      : clcs_pkg::ST_SC_RD1;
            end
            clcs_pkg::ST_SC_RD1: state_next = clcs_pkg::ST_SC_WR;
            clcs_pkg::ST_SC_WR:  state_next = clcs_pkg::ST_SC_RD0;
            clcs_pkg::ST_RQ:     state_next = clcs_pkg::ST_RS;
            clcs_pkg::ST_RS:     state_next = clcs_pkg::ST_DONE;
            clcs_pkg::ST_DONE:   if (out_free) state_next = clcs_pkg::ST_IDLE;
            default:             state_next = clcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        pidx_next     = pidx_reg;
        loaded_next   = loaded_reg;
        ovf_next      = ovf_reg;
        pend_next     = pend_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        creq_next     = creq_reg;
        id_next       = id_reg;
        res_cell_next = res_cell_reg;
        res_part_next = res_part_reg;
        res_off_next  = res_off_reg;
        res_cnt_next  = res_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        cnt_we = 1'b0; cnt_waddr = idx_reg[CW-1:0]; cnt_wdata = 13'd0;
        off_we = 1'b0; off_waddr = idx_reg[CW-1:0]; off_wdata = 13'd0;
        cur_we = 1'b0; cur_waddr = idx_reg[CW-1:0]; cur_wdata = 13'd0;
        pc_we  = 1'b0; pc_waddr  = loaded_reg[PW-1:0]; pc_wdata = id_reg;
        ss_we  = 1'b0; ss_waddr  = slot_k[PW-1:0];     ss_wdata = pidx_reg[11:0];
        cnt_raddr = creq_reg;
        off_raddr = creq_reg;
        cur_raddr = id_reg;
        pc_raddr  = pidx_reg[PW-1:0];
        ss_raddr  = slot_reg;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        case (state_reg)
            clcs_pkg::ST_CLEAR: begin
                cnt_we   = 1'b1;
                off_we   = 1'b1;
                cur_we   = 1'b1;
                idx_next = idx_reg + 13'd1;
            end
            clcs_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next       = s_tuser;
                    slot_next     = s_tdata[75:64];
                    creq_next     = s_tdata[87:76];
                    pend_next     = 1'b1;
                    idx_next      = 13'd0;
                    acc_next      = 13'd0;
                    pidx_next     = 13'd0;
                    res_cell_next = 12'd0;
                    res_part_next = 12'd0;
                    res_off_next  = 13'd0;
                    res_cnt_next  = 13'd0;
                    if (s_tuser == clcs_pkg::OP_CLEAR) begin
                        loaded_next = 13'd0;
                        ovf_next    = 1'b0;
                    end
                    if (s_tuser == clcs_pkg::OP_LOAD && full) ovf_next = 1'b1;
                end
            end
            clcs_pkg::ST_AXIS: begin
                if (x_done) begin
                    id_next = (id_full >= clcs_pkg::MAX_CELLS) ? clcs_pkg::LAST_CELL[11:0]
                                                               : id_full[11:0];
                end
            end
            clcs_pkg::ST_LD_RD: begin
                cnt_raddr = id_reg;
            end
            clcs_pkg::ST_LD_WR: begin
                cnt_we        = 1'b1;
                cnt_waddr     = id_reg;
                cnt_wdata     = cnt_rdata + 13'd1;
                pc_we         = 1'b1;
                loaded_next   = loaded_reg + 13'd1;
                res_cell_next = id_reg;
            end
            clcs_pkg::ST_PFX: begin
                cnt_raddr = idx_reg[CW-1:0];
                if (idx_reg != 13'd0) begin
                    off_we    = 1'b1;
                    off_waddr = CW'(idx_reg - 13'd1);
                    off_wdata = acc_reg;
                    cur_we    = 1'b1;
                    cur_waddr = CW'(idx_reg - 13'd1);
                    cur_wdata = 13'd0;
                    acc_next  = acc_reg + cnt_rdata;
                end
                idx_next = idx_reg + 13'd1;
            end
            clcs_pkg::ST_SC_RD1: begin
                off_raddr = pc_rdata;
                cur_raddr = pc_rdata;
                id_next   = pc_rdata;
            end
            clcs_pkg::ST_SC_WR: begin
                ss_we     = (slot_k < 14'(clcs_pkg::MAX_PARTICLES));
                cur_we    = 1'b1;
                cur_waddr = id_reg;
                cur_wdata = cur_rdata + 13'd1;
                pidx_next = pidx_reg + 13'd1;
            end
            clcs_pkg::ST_RS: begin
                if (op_reg == clcs_pkg::OP_RSLOT) begin
                    res_part_next = ({1'b0, slot_reg} < loaded_reg) ? ss_rdata : 12'd0;
                end else begin
                    res_off_next = off_rdata;
                    res_cnt_next = cnt_rdata;
                end
            end
            clcs_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {ovf_reg, loaded_reg, res_cnt_reg, res_off_reg,
                                     res_part_reg, res_cell_reg};
                    pend_next     = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= clcs_pkg::ST_CLEAR;
            idx_reg      <= 13'd0;
            loaded_reg   <= 13'd0;
            ovf_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cells_x_reg  <= 7'd1;
            cells_y_reg  <= 7'd1;
            inv_reg      <= 24'd65536;
            wrap_reg     <= 1'b1;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            loaded_reg   <= loaded_next;
            ovf_reg      <= ovf_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    clcs_pkg::CFG_CELLS_X:  cells_x_reg <= cfg_data[6:0];
                    clcs_pkg::CFG_CELLS_Y:  cells_y_reg <= cfg_data[6:0];
                    clcs_pkg::CFG_INV_SIZE: inv_reg     <= cfg_data;
                    clcs_pkg::CFG_WRAP:     wrap_reg    <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        acc_reg      <= acc_next;
        pidx_reg     <= pidx_next;
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        creq_reg     <= creq_next;
        id_reg       <= id_next;
        res_cell_reg <= res_cell_next;
        res_part_reg <= res_part_next;
        res_off_reg  <= res_off_next;
        res_cnt_reg  <= res_cnt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (off_we) off_mem[off_waddr] <= off_wdata;
        off_rdata <= off_mem[off_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
        cur_rdata <= cur_mem[cur_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pc_we) pc_mem[pc_waddr] <= pc_wdata;
        pc_rdata <= pc_mem[pc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (ss_we) ss_mem[ss_waddr] <= ss_wdata;
        ss_rdata <= ss_mem[ss_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `CLCS_ASSERT_ALWAYS(a_total_bound, loaded_reg <= clcs_pkg::MAX_PARTICLES)
    `CLCS_ASSERT_ALWAYS(a_axes_lockstep, x_done == y_done)
    `CLCS_ASSERT_NEXT(a_ovf_sticky, ovf_reg && !(accept && s_tuser == clcs_pkg::OP_CLEAR), ovf_reg)
    `CLCS_ASSERT_NEXT(a_done_delivers, state_reg == clcs_pkg::ST_DONE && out_free, m_tvalid_reg)
    `CLCS_ASSERT_IMPLY(a_scatter_range, state_reg == clcs_pkg::ST_SC_WR, pidx_reg < loaded_reg)

endmodule

// ----- tb/tb_cell_list_counting_sort.sv -----
// Self-checking testbench for the cell list counting sort block.
`timescale 1ns / 1ps

module tb_cell_list_counting_sort;

    localparam int NCELL = 4096;
    localparam int NPART = 4096;
    localparam int STALL_LIMIT = 60000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] px;
        logic [31:0] py;
        logic [11:0] slot;
        logic [11:0] creq;
    } command_t;

    typedef struct {
        logic [11:0] cell_id;
        logic [11:0] pidx;
        logic [12:0] offset;
        logic [12:0] count;
        logic [12:0] total;
        logic        ovf;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // pos_x, pos_y, slot, cell_req
    logic [2:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // cell_id, particle_index, cell_offset, cell_count,
                            // particle_total, overflow
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    cell_list_counting_sort dut (.*);

    // Own copy of the block's configuration and list.
    logic [6:0]  grid_x, grid_y;
    logic [23:0] inv_size;
    logic        wrap_on;
    logic [11:0] cell_of_particle [NPART];
    logic [11:0] slot_particle [NPART];
    bit          slot_built [NPART];
    logic [12:0] cell_count [NCELL];
    logic [12:0] cell_offset [NCELL];
    logic [12:0] cell_cursor [NCELL];
    logic [12:0] loaded;
    logic        overflowed;

    command_t cmd_queue[$];
    answer_t  result_queue[$];
    int       errors;
    int       idle_cycles;
    bit       idling_on;
    int       send_gap, recv_gap, recv_hold;
    int       hold_req, hold_ack;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int grid_size(logic [6:0] n);
        if (n == 0) return 1;
        if (n > 64) return 64;
        return int'(n);
    endfunction

    function automatic int axis_to_cell(logic [31:0] pos, int n);
        longint prod, c;
        prod = longint'($signed(pos)) * longint'({40'd0, inv_size});
        c = prod >>> 32;
        if (wrap_on) begin
            c = c % n;
            if (c < 0) c += n;
            return int'(c);
        end
        if (c < 0) return 0;
        if (c >= n) return n - 1;
        return int'(c);
    endfunction

    function automatic void wipe_list();
        for (int c = 0; c < NCELL; c++) begin
            cell_count[c] = '0;
            cell_offset[c] = '0;
            cell_cursor[c] = '0;
        end
        loaded = '0;
        overflowed = 1'b0;
    endfunction

    function automatic answer_t predict_command(command_t cmd);
        answer_t a;
        int nx, ny, id, k;
        logic [12:0] acc;
        a = '{default: '0};
        case (cmd.op)
            clcs_pkg::OP_CLEAR: wipe_list();
            clcs_pkg::OP_LOAD: begin
                if (loaded >= NPART) begin
                    overflowed = 1'b1;
                end else begin
                    nx = grid_size(grid_x);
                    ny = grid_size(grid_y);
                    id = axis_to_cell(cmd.py, ny) * nx + axis_to_cell(cmd.px, nx);
                    if (id >= NCELL) id = NCELL - 1;
                    cell_of_particle[loaded] = id[11:0];
                    cell_count[id] = cell_count[id] + 13'd1;
                    loaded = loaded + 13'd1;
                    a.cell_id = id[11:0];
                end
            end
            clcs_pkg::OP_BUILD: begin
                acc = '0;
                for (int c = 0; c < NCELL; c++) begin
                    cell_offset[c] = acc;
                    acc = acc + cell_count[c];
                    cell_cursor[c] = '0;
                end
                for (int i = 0; i < loaded; i++) begin
                    id = cell_of_particle[i];
                    k = cell_offset[id] + cell_cursor[id];
                    if (k < NPART) begin
                        slot_particle[k] = i[11:0];
                        slot_built[k] = 1'b1;
                    end
                    cell_cursor[id] = cell_cursor[id] + 13'd1;
                end
            end
            clcs_pkg::OP_RSLOT: if (cmd.slot < loaded) a.pidx = slot_particle[cmd.slot];
            clcs_pkg::OP_RCELL: begin
                a.offset = cell_offset[cmd.creq];
                a.count = cell_count[cmd.creq];
            end
            default: ;
        endcase
        a.total = loaded;
        a.ovf = overflowed;
        return a;
    endfunction

    task automatic issue(logic [2:0] op, logic [31:0] px = '0, logic [31:0] py = '0,
                         logic [11:0] slot = '0, logic [11:0] creq = '0);
        command_t cmd;
        cmd = '{op, px, py, slot, creq};
        result_queue.push_back(predict_command(cmd));
        cmd_queue.push_back(cmd);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || result_queue.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            clcs_pkg::CFG_CELLS_X:  grid_x = value[6:0];
            clcs_pkg::CFG_CELLS_Y:  grid_y = value[6:0];
            clcs_pkg::CFG_INV_SIZE: inv_size = value;
            clcs_pkg::CFG_WRAP:     wrap_on = value[0];
            default: ;
        endcase
    endtask

    task automatic report(string field, longint got, longint want);
        errors++;
        $display("mismatch in %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
    endtask

    function automatic logic [31:0] pick_position();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endfunction

    function automatic logic [11:0] pick_slot(output bit ok);
        logic [11:0] s;
        for (int t = 0; t < 8; t++) begin
            s = ($urandom_range(0, 3) == 0) ? 12'($urandom())
                                             : 12'($urandom_range(0, loaded + 3));
            if (s >= loaded || slot_built[s]) begin
                ok = 1'b1;
                return s;
            end
        end
        ok = 1'b0;
        return '0;
    endfunction

    function automatic logic [11:0] pick_cell();
        if ($urandom_range(0, 2) == 0) return 12'($urandom());
        if (loaded != 0 && $urandom_range(0, 1) == 0)
            return cell_of_particle[$urandom_range(0, loaded - 1)];
        return 12'($urandom_range(0, 80));
    endfunction

    // Sender: offers commands from the queue, with random idle bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tuser <= cmd_queue[0].op;
                s_tdata <= {cmd_queue[0].creq, cmd_queue[0].slot, cmd_queue[0].py,
                            cmd_queue[0].px};
                void'(cmd_queue.pop_front());
                if (idling_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer and stalls at random.
    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
            recv_hold <= 0;
            hold_ack <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    report("unexpected result", m_tdata, 0);
                end else begin
                    want = result_queue.pop_front();
                    if (m_tdata[11:0] != want.cell_id) report("cell_id", m_tdata[11:0], want.cell_id);
                    if (m_tdata[23:12] != want.pidx)
                        report("particle_index", m_tdata[23:12], want.pidx);
                    if (m_tdata[36:24] != want.offset)
                        report("cell_offset", m_tdata[36:24], want.offset);
                    if (m_tdata[49:37] != want.count)
                        report("cell_count", m_tdata[49:37], want.count);
                    if (m_tdata[62:50] != want.total)
                        report("particle_total", m_tdata[62:50], want.total);
                    if (m_tdata[63] != want.ovf) report("overflow", m_tdata[63], want.ovf);
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack <= hold_req;
                recv_hold <= 400;
                m_tready <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 15);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("** cell_list_counting_sort: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        bit ok;
        int done, n;
        logic [11:0] s;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        idling_on = 1'b1;
        hold_req = 0;
        grid_x = 7'd1;
        grid_y = 7'd1;
        inv_size = 24'd65536;
        wrap_on = 1'b1;
        for (int i = 0; i < NPART; i++) begin
            slot_built[i] = 1'b0;
            slot_particle[i] = '0;
            cell_of_particle[i] = '0;
        end
        wipe_list();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: field extremes, every operation, unused opcodes.
        issue(clcs_pkg::OP_RCELL, 0, 0, 0, 12'd0);
        issue(clcs_pkg::OP_RSLOT, 0, 0, 12'd0, 0);
        issue(clcs_pkg::OP_BUILD);
        issue(clcs_pkg::OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(clcs_pkg::OP_LOAD, 32'h0000_0000, 32'hFFFF_FFFF);
        issue(clcs_pkg::OP_LOAD, 32'hFFFF_FFFF, 32'h8000_0000);
        issue(clcs_pkg::OP_RCELL, 0, 0, 0, 12'd0);
        issue(clcs_pkg::OP_BUILD);
        issue(clcs_pkg::OP_RSLOT, 0, 0, 12'd0, 0);
        issue(clcs_pkg::OP_RSLOT, 0, 0, 12'd2, 0);
        issue(clcs_pkg::OP_RSLOT, 0, 0, 12'd4095, 12'd4095);
        issue(clcs_pkg::OP_RCELL, 0, 0, 12'd4095, 12'd4095);
        issue(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF);
        issue(3'd7);
        issue(clcs_pkg::OP_LOAD, 32'h0001_0000, 32'h0002_0000);
        issue(clcs_pkg::OP_RCELL, 0, 0, 0, 12'd0);
        issue(clcs_pkg::OP_CLEAR);
        issue(clcs_pkg::OP_RCELL, 0, 0, 0, 12'd0);
        wait_drained();
        write_reg(clcs_pkg::CFG_CELLS_X, 24'd127);
        write_reg(clcs_pkg::CFG_CELLS_Y, 24'd0);
        write_reg(clcs_pkg::CFG_WRAP, 24'd0);
        write_reg(clcs_pkg::CFG_INV_SIZE, 24'hFFFFFF);
        issue(clcs_pkg::OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        issue(clcs_pkg::OP_LOAD, 32'h8000_0000, 32'h0000_0001);
        issue(clcs_pkg::OP_BUILD);
        issue(clcs_pkg::OP_RCELL, 0, 0, 0, 12'd63);
        issue(clcs_pkg::OP_RSLOT, 0, 0, 12'd1, 0);
        wait_drained();

        // Fill the list to capacity, then overflow it; the receiver holds off once at the start.
        hold_req++;
        issue(clcs_pkg::OP_CLEAR);
        for (int i = 0; i < NPART + 3; i++)
            issue(clcs_pkg::OP_LOAD, pick_position(), pick_position());
        issue(clcs_pkg::OP_BUILD);
        for (int i = 0; i < 12; i++) issue(clcs_pkg::OP_RSLOT, 0, 0, 12'($urandom()), 0);
        issue(clcs_pkg::OP_RCELL, 0, 0, 0, pick_cell());
        issue(clcs_pkg::OP_CLEAR);
        issue(clcs_pkg::OP_LOAD, pick_position(), pick_position());
        wait_drained();

        // Random phases: a new setting, then load/build/read sequences mixed with unused opcodes.
        done = 0;
        while (done < 1150) begin
            if (done > 1000) idling_on = 1'b0;
            case ($urandom_range(0, 3))
                0: write_reg(clcs_pkg::CFG_CELLS_X,
                             $urandom_range(0, 3) == 0 ? 24'd64 : 24'($urandom_range(0, 127)));
                1: write_reg(clcs_pkg::CFG_CELLS_Y,
                             $urandom_range(0, 3) == 0 ? 24'd1 : 24'($urandom_range(0, 127)));
                2: write_reg(clcs_pkg::CFG_INV_SIZE, $urandom_range(0, 2) == 0 ? 24'($urandom()) :
                             ($urandom_range(0, 1) ? 24'd65536 : 24'd16384));
                default: write_reg(clcs_pkg::CFG_WRAP, 24'($urandom_range(0, 1)));
            endcase
            if (idling_on && $urandom_range(0, 5) == 0) hold_req++;
            issue(clcs_pkg::OP_CLEAR);
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
                issue(clcs_pkg::OP_LOAD, pick_position(), pick_position());
            issue(clcs_pkg::OP_BUILD);
            done += n + 2;
            for (int i = 0; i < 20; i++) begin
                case ($urandom_range(0, 6))
                    0: issue(clcs_pkg::OP_LOAD, pick_position(), pick_position());
                    1: issue(3'($urandom_range(5, 7)), $urandom(), $urandom(),
                             12'($urandom()), 12'($urandom()));
                    2, 3: begin
                        s = pick_slot(ok);
                        if (ok) issue(clcs_pkg::OP_RSLOT, $urandom(), $urandom(), s,
                                      12'($urandom()));
                    end
                    default: issue(clcs_pkg::OP_RCELL, $urandom(), $urandom(),
                                   12'($urandom()), pick_cell());
                endcase
                done++;
            end
            if ($urandom_range(0, 2) == 0) begin
                issue(clcs_pkg::OP_BUILD);
                for (int i = 0; i < 5; i++) begin
                    s = pick_slot(ok);
                    if (ok) issue(clcs_pkg::OP_RSLOT, 0, 0, s, 0);
                end
                done += 6;
            end
            wait_drained();
        end

        wait_drained();
        repeat (30) @(posedge aclk);
        if (errors == 0 && result_queue.size() == 0)
            $display("** cell_list_counting_sort: PASSED **");
        else
            $display("** cell_list_counting_sort: FAILED **");
        $finish;
    end

endmodule
